[design/dart_pkg.sv]
// Shared types and constants for the DAG reachability and dirty tracker.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package dart_pkg;

   localparam int NODES  = 64;
   localparam int ADDR_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int MODE_W = 3;
   localparam int NODE_W = 6;
   localparam int REQ_W  = 16;
   localparam int RSP_W  = 8;

   localparam logic [MODE_W-1:0] MODE_ADD_EDGE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MARK_ABOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAN      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REINIT     = 3'd4;

   typedef logic [NODES-1:0]  col_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [1:0] {
      RD_CHILD = 2'd0,
      RD_NODE  = 2'd1,
      RD_SCAN  = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       cnt_clear;
      logic       scan;
      logic       union_cap;
      logic       col_write;
      logic       query_cap;
      logic       clean;
      logic       reinit;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              in_range;
      logic              cnt_last;
      logic              rsp_busy;
   } status_type;

   function automatic logic node_ok(input logic [NODE_W-1:0] n);
      return 32'(n) < NODES;
   endfunction

endpackage

[design/dart_ctrl.sv]
// Sequencer of the tracker: steps each request through reads, writes and
// the column scan. Drives dart_dpath by command struct; uses dart_pkg.
`timescale 1ns / 1ps

module dart_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  dart_pkg::status_type status,
   output dart_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_DISPATCH   = 8'b0000_0010,
      ST_ADD_PARENT = 8'b0000_0100,
      ST_ADD_WRITE  = 8'b0000_1000,
      ST_QUERY      = 8'b0001_0000,
      ST_MARK       = 8'b0010_0000,
      ST_MARK_DRAIN = 8'b0100_0000,
      ST_FINISH     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = dart_pkg::RD_NODE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (!status.in_range) begin
               state_in = ST_FINISH;
            end else if (status.mode == dart_pkg::MODE_ADD_EDGE) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dart_pkg::RD_CHILD;
               state_in   = ST_ADD_PARENT;
            end else if (status.mode == dart_pkg::MODE_MARK_ABOVE) begin
               cmd.cnt_clear = 1'b1;
               state_in      = ST_MARK;
            end else if (status.mode == dart_pkg::MODE_QUERY) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_QUERY;
            end else if (status.mode == dart_pkg::MODE_CLEAN) begin
               cmd.clean = 1'b1;
               state_in  = ST_FINISH;
            end else if (status.mode == dart_pkg::MODE_REINIT) begin
               cmd.reinit = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_ADD_PARENT: begin
            // Child columns arrive now; fetch the parent's column next.
            cmd.union_cap = 1'b1;
            cmd.rd_en     = 1'b1;
            state_in      = ST_ADD_WRITE;
         end
         ST_ADD_WRITE: begin
            cmd.col_write = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_QUERY: begin
            cmd.query_cap = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_MARK: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = dart_pkg::RD_SCAN;
            cmd.scan   = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_MARK_DRAIN;
            end
         end
         ST_MARK_DRAIN: begin
            // The last column read is folded into the dirty vectors here.
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/dart_dpath.sv]
// Datapath of the tracker: column memories with per-entry valid bits,
// dirty vectors, scan counter and response register. Uses dart_pkg.
`timescale 1ns / 1ps

module dart_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  dart_pkg::cmd_type             cmd,
   output dart_pkg::status_type          status,
   input  logic [dart_pkg::MODE_W-1:0]   req_mode,
   input  logic [dart_pkg::NODE_W-1:0]   req_node,
   input  logic [dart_pkg::NODE_W-1:0]   req_child,
   input  logic                          req_side,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          rsp_dirty_found
);

   dart_pkg::col_type mem_left  [dart_pkg::NODES];
   dart_pkg::col_type mem_right [dart_pkg::NODES];

   logic [dart_pkg::MODE_W-1:0] mode_ff;
   logic [dart_pkg::NODE_W-1:0] node_ff, child_ff;
   logic                        side_ff;

   dart_pkg::col_type  vld_left_ff, vld_right_ff;
   dart_pkg::col_type  dirty_left_ff, dirty_right_ff;
   dart_pkg::col_type  rd_left_ff, rd_right_ff;
   logic               rd_vld_left_ff, rd_vld_right_ff;
   dart_pkg::addr_type raddr_ff;
   dart_pkg::col_type  union_ff;
   dart_pkg::addr_type cnt_ff;
   logic               scan_ff;
   logic               found_ff;
   logic               rsp_valid_ff, rsp_found_ff;

   dart_pkg::addr_type rd_addr, node_addr;
   dart_pkg::col_type  id_col, left_col, right_col, wr_col;
   logic               range_ok;

   assign node_addr = dart_pkg::addr_type'(node_ff);

   always_comb begin
      unique case (cmd.rd_sel)
         dart_pkg::RD_CHILD: rd_addr = dart_pkg::addr_type'(child_ff);
         dart_pkg::RD_NODE:  rd_addr = node_addr;
         dart_pkg::RD_SCAN:  rd_addr = cnt_ff;
         default:            rd_addr = cnt_ff;
      endcase
   end

   // A column never written since reset or reinit reads as its identity column.
   assign id_col    = dart_pkg::col_type'(1) << raddr_ff;
   assign left_col  = rd_vld_left_ff  ? rd_left_ff  : id_col;
   assign right_col = rd_vld_right_ff ? rd_right_ff : id_col;
   assign wr_col    = (side_ff ? left_col : right_col) | union_ff;

   always_comb begin
      if (mode_ff == dart_pkg::MODE_ADD_EDGE) begin
         range_ok = dart_pkg::node_ok(node_ff) && dart_pkg::node_ok(child_ff);
      end else if (mode_ff == dart_pkg::MODE_MARK_ABOVE ||
                   mode_ff == dart_pkg::MODE_QUERY) begin
         range_ok = dart_pkg::node_ok(node_ff);
      end else begin
         range_ok = 1'b1;
      end
   end

   assign status.mode     = mode_ff;
   assign status.in_range = range_ok;
   assign status.cnt_last = (cnt_ff == dart_pkg::addr_type'(dart_pkg::NODES - 1));
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

   // Request fields and column memories.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         node_ff  <= req_node;
         child_ff <= req_child;
         side_ff  <= req_side;
      end
      if (cmd.rd_en) begin
         rd_left_ff      <= mem_left[rd_addr];
         rd_right_ff     <= mem_right[rd_addr];
         rd_vld_left_ff  <= vld_left_ff[rd_addr];
         rd_vld_right_ff <= vld_right_ff[rd_addr];
         raddr_ff        <= rd_addr;
      end
      if (cmd.col_write && side_ff) begin
         mem_left[node_addr] <= wr_col;
      end
      if (cmd.col_write && !side_ff) begin
         mem_right[node_addr] <= wr_col;
      end
      if (cmd.union_cap) begin
         union_ff <= left_col | right_col;
      end
      if (cmd.rsp_load) begin
         rsp_found_ff <= found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_left_ff    <= '0;
         vld_right_ff   <= '0;
         dirty_left_ff  <= '0;
         dirty_right_ff <= '0;
         cnt_ff         <= '0;
         scan_ff        <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         scan_ff <= cmd.scan;

         if (cmd.cnt_clear) begin
            cnt_ff <= '0;
         end else if (cmd.scan) begin
            cnt_ff <= cnt_ff + dart_pkg::addr_type'(1);
         end

         if (cmd.reinit) begin
            vld_left_ff  <= '0;
            vld_right_ff <= '0;
         end else if (cmd.col_write) begin
            if (side_ff) begin
               vld_left_ff[node_addr] <= 1'b1;
            end else begin
               vld_right_ff[node_addr] <= 1'b1;
            end
         end

         // Column raddr_ff holds the subject in its row: that column's node is above it.
         if (cmd.clean || cmd.reinit) begin
            dirty_left_ff  <= '0;
            dirty_right_ff <= '0;
         end else if (scan_ff && raddr_ff != node_addr) begin
            if (left_col[node_addr]) begin
               dirty_left_ff[raddr_ff] <= 1'b1;
            end
            if (right_col[node_addr]) begin
               dirty_right_ff[raddr_ff] <= 1'b1;
            end
         end

         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (cmd.query_cap) begin
            found_ff <= side_ff ? |(left_col & dirty_left_ff)
                                : |(right_col & dirty_right_ff);
         end

         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_dirty_found = rsp_found_ff;

endmodule

[design/dag_reachability_dirty_tracker.sv]
// Top level of the DAG reachability and dirty tracker: stream ports,
// field unpacking, dart_ctrl and dart_dpath. Uses dart_pkg.
`timescale 1ns / 1ps

// Every request returns exactly one response. A request passes a dispatch
// state and ends in a finish state, which loads its response once no
// earlier response still waits. Between the two, query adds a capture,
// add_edge a parent read and a column write, and mark_above a scan and a
// drain; clean, reinit, unused modes and out-of-range nodes add none. The
// scan reads one column per cycle through the single read port of each
// column memory. A new request is taken when the block is idle, even while
// the previous response still waits. No clearing pass is needed after reset
// or reinit: per-column valid bits make untouched columns read as identity.
module dag_reachability_dirty_tracker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // Fields from bit 0: mode[2:0], node[8:3], child[14:9], side[15].
   input  logic [dart_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // Fields from bit 0: dirty_found[0], zero fill [7:1].
   output logic [dart_pkg::RSP_W-1:0]   rsp_tdata
);

   dart_pkg::cmd_type    cmd;
   dart_pkg::status_type status;
   logic                 rsp_dirty_found;

   dart_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dart_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_tdata[2:0]),
      .req_node        (req_tdata[8:3]),
      .req_child       (req_tdata[14:9]),
      .req_side        (req_tdata[15]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_dirty_found (rsp_dirty_found)
   );

   assign rsp_tdata = {{(dart_pkg::RSP_W - 1){1'b0}}, rsp_dirty_found};

endmodule

[design/dart_checker.sv]
// Port-level checker for the tracker, bound to the top level.
// Tracks outstanding requests; uses dart_pkg for port widths.
`timescale 1ns / 1ps

module dart_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [dart_pkg::RSP_W-1:0] rsp_tdata
);

   logic [1:0] pending_ff;
   logic       req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else if (req_acc && !rsp_acc) begin
         pending_ff <= pending_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pending_ff <= pending_ff - 2'd1;
      end
   end

   // A stalled response keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No response appears without a request that is still owed one.
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("response without an outstanding request");

   // One request in work and one response waiting is the most the block holds.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_tready && rsp_tvalid)
      else $error("request taken while block is full");

   a_pending_max: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many outstanding requests");

endmodule

bind dag_reachability_dirty_tracker dart_checker u_dart_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/dag_reachability_dirty_tracker_tb.sv]
// Self-checking testbench for dag_reachability_dirty_tracker: random and directed
// requests, its own copy of the reachability matrices and dirty vectors, in-order
// response checking. Depends on dart_pkg and the top level of the block.
`timescale 1ns / 1ps

module dag_reachability_dirty_tracker_tb;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int HOLDOFF_AFTER = 150;
   localparam int HOLDOFF_LEN   = 400;
   localparam int RANDOM_COUNT  = 580;
   localparam int REPORT_MAX    = 10;

   // Packed so that mode lands in the lowest bits, as on req_tdata.
   typedef struct packed {
      logic                        side;
      logic [dart_pkg::NODE_W-1:0] child;
      logic [dart_pkg::NODE_W-1:0] node;
      logic [dart_pkg::MODE_W-1:0] mode;
   } tracker_request_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [dart_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [dart_pkg::RSP_W-1:0] rsp_tdata;

   // Model state of the tracker.
   logic [dart_pkg::NODES-1:0] below_left  [dart_pkg::NODES];
   logic [dart_pkg::NODES-1:0] below_right [dart_pkg::NODES];
   logic [dart_pkg::NODES-1:0] dirty_left;
   logic [dart_pkg::NODES-1:0] dirty_right;

   tracker_request_type pending_requests[$];
   logic             expected_found[$];
   int               total_requests;
   int               requests_accepted = 0;
   int               mismatch_count    = 0;
   bit               failed            = 1'b0;
   int               cycle_count       = 0;

   // Sender burst state.
   int               burst_left = 0;
   int               gap_left   = 0;

   // Receiver stall state.
   int               style      = 0;
   int               style_left = 0;
   int               holdoff_left = 0;
   bit               holdoff_done = 1'b0;
   int               responses_seen = 0;

   dag_reachability_dirty_tracker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void restore_identity();
      for (int j = 0; j < dart_pkg::NODES; j++) begin
         below_left[j]  = '0;
         below_right[j] = '0;
         below_left[j][j]  = 1'b1;
         below_right[j][j] = 1'b1;
      end
      dirty_left  = '0;
      dirty_right = '0;
   endfunction

   // Applies one request to the model state and returns the expected dirty_found.
   function automatic logic apply_request(input tracker_request_type r);
      logic                       found;
      logic [dart_pkg::NODES-1:0] merged;
      found = 1'b0;
      case (r.mode)
         dart_pkg::MODE_ADD_EDGE: begin
            if (int'(r.node) < dart_pkg::NODES && int'(r.child) < dart_pkg::NODES) begin
               merged = below_left[r.child] | below_right[r.child];
               if (r.side)
                  below_left[r.node] = below_left[r.node] | merged;
               else
                  below_right[r.node] = below_right[r.node] | merged;
            end
         end
         dart_pkg::MODE_MARK_ABOVE: begin
            if (int'(r.node) < dart_pkg::NODES) begin
               for (int j = 0; j < dart_pkg::NODES; j++) begin
                  if (j != int'(r.node)) begin
                     if (below_right[j][r.node]) dirty_right[j] = 1'b1;
                     if (below_left[j][r.node])  dirty_left[j]  = 1'b1;
                  end
               end
            end
         end
         dart_pkg::MODE_QUERY: begin
            if (int'(r.node) < dart_pkg::NODES) begin
               if (r.side)
                  found = |(below_left[r.node] & dirty_left);
               else
                  found = |(below_right[r.node] & dirty_right);
            end
         end
         dart_pkg::MODE_CLEAN: begin
            dirty_left  = '0;
            dirty_right = '0;
         end
         dart_pkg::MODE_REINIT: restore_identity();
         default: ;
      endcase
      return found;
   endfunction

   task automatic queue_request(input logic [dart_pkg::MODE_W-1:0] mode, input int node,
                                input int child, input logic side);
      tracker_request_type r;
      r.mode  = mode;
      r.node  = dart_pkg::NODE_W'(node);
      r.child = dart_pkg::NODE_W'(child);
      r.side  = side;
      pending_requests.push_back(r);
   endtask

   // Mostly small node numbers so that edges chain up and queries find dirt.
   function automatic int pick_node();
      if ($urandom_range(0, 3) != 0)
         return $urandom_range(0, 15);
      return $urandom_range(0, dart_pkg::NODES - 1);
   endfunction

   initial begin
      int pick;
      logic [dart_pkg::MODE_W-1:0] mode;
      reset = 1'b1;
      restore_identity();

      // Directed opening: extremes, self edge, unused modes, clean and reinit.
      queue_request(dart_pkg::MODE_REINIT, 0, 0, 1'b1);
      queue_request(dart_pkg::MODE_QUERY, 0, 63, 1'b0);
      queue_request(dart_pkg::MODE_ADD_EDGE, 63, 0, 1'b1);
      queue_request(dart_pkg::MODE_ADD_EDGE, 0, 63, 1'b0);
      queue_request(dart_pkg::MODE_ADD_EDGE, 5, 5, 1'b1);
      queue_request(dart_pkg::MODE_ADD_EDGE, 5, 5, 1'b0);
      queue_request(dart_pkg::MODE_MARK_ABOVE, 0, 63, 1'b0);
      queue_request(dart_pkg::MODE_QUERY, 63, 0, 1'b1);
      queue_request(dart_pkg::MODE_QUERY, 63, 0, 1'b0);
      queue_request(dart_pkg::MODE_MARK_ABOVE, 63, 0, 1'b1);
      queue_request(dart_pkg::MODE_QUERY, 0, 0, 1'b0);
      queue_request(3'd5, 63, 63, 1'b1);
      queue_request(3'd6, 0, 63, 1'b0);
      queue_request(3'd7, 63, 0, 1'b1);
      queue_request(dart_pkg::MODE_CLEAN, 63, 63, 1'b1);
      queue_request(dart_pkg::MODE_QUERY, 63, 63, 1'b1);
      queue_request(dart_pkg::MODE_ADD_EDGE, 62, 63, 1'b0);
      queue_request(dart_pkg::MODE_MARK_ABOVE, 63, 63, 1'b1);
      queue_request(dart_pkg::MODE_QUERY, 62, 0, 1'b0);
      queue_request(dart_pkg::MODE_QUERY, 0, 0, 1'b0);
      queue_request(dart_pkg::MODE_REINIT, 63, 63, 1'b0);
      queue_request(dart_pkg::MODE_QUERY, 0, 0, 1'b1);

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)      mode = dart_pkg::MODE_ADD_EDGE;
         else if (pick < 52) mode = dart_pkg::MODE_MARK_ABOVE;
         else if (pick < 89) mode = dart_pkg::MODE_QUERY;
         else if (pick < 94) mode = dart_pkg::MODE_CLEAN;
         else if (pick < 96) mode = dart_pkg::MODE_REINIT;
         else                mode = dart_pkg::MODE_W'($urandom_range(5, 7));
         queue_request(mode, pick_node(), pick_node(), 1'($urandom_range(0, 1)));
      end
      total_requests = pending_requests.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (requests_accepted < total_requests || expected_found.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed && mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_tdata  <= pending_requests.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver: changing stall styles, plus one long hold-off that
   // lets the block fill up while requests keep coming.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) responses_seen++;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else if (!holdoff_done && responses_seen >= HOLDOFF_AFTER) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_LEN;
            rsp_tready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = $urandom_range(0, 2);
               style_left = $urandom_range(20, 150);
            end else begin
               style_left--;
            end
            case (style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Monitor: responses are checked before the request of the same edge is
   // predicted, since a response always belongs to an earlier request.
   always @(posedge clock) begin
      logic found;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_found.size() == 0) begin
               failed = 1'b1;
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("Unexpected response %h with no request waiting", rsp_tdata);
            end else begin
               found = expected_found.pop_front();
               if (rsp_tdata !== {{(dart_pkg::RSP_W - 1){1'b0}}, found}) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("Response mismatch: dirty_found expected %b, got %b (tdata %h)",
                              found, rsp_tdata[0], rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_found.push_back(apply_request(tracker_request_type'(req_tdata)));
            requests_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule

[files.f]
design/dart_pkg.sv
design/dart_ctrl.sv
design/dart_dpath.sv
design/dag_reachability_dirty_tracker.sv
design/dart_checker.sv
tb/dag_reachability_dirty_tracker_tb.sv
